FILE: hw/rtl/multi_stream_lcg_range_draw_macros.svh
// Assertion helpers for the generator block.
`ifndef MULTI_STREAM_LCG_RANGE_DRAW_MACROS_SVH
`define MULTI_STREAM_LCG_RANGE_DRAW_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MSLRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MSLRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mslrd_pkg.sv
package mslrd_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned STREAMS = 4;
  localparam int unsigned SIDX_W  = 2;

  localparam logic [DATA_W-1:0] MULT_RESET = 32'd16807;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_SIGN        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_WEIGHT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_NUMBER_SEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_LENGTH      = 2'd3;

  // Opcodes: bit 2 selects draw, low bits select the stream
  localparam logic [OP_W-1:0] OP_SEED_LENGTH = 3'd0;
  localparam logic [OP_W-1:0] OP_SEED_WEIGHT = 3'd1;
  localparam logic [OP_W-1:0] OP_SEED_SIGN   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEED_NUMBER = 3'd3;
  localparam logic [OP_W-1:0] OP_DRAW_LENGTH = 3'd4;
  localparam logic [OP_W-1:0] OP_DRAW_WEIGHT = 3'd5;
  localparam logic [OP_W-1:0] OP_DRAW_SIGN   = 3'd6;
  localparam logic [OP_W-1:0] OP_DRAW_NUMBER = 3'd7;

  // Microprogram addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_SEED  = 3'd0;
  localparam step_t ST_CHECK = 3'd1;
  localparam step_t ST_ADV   = 3'd2;
  localparam step_t ST_SCALE = 3'd3;
  localparam step_t ST_SUM   = 3'd4;
  localparam step_t ST_DEGEN = 3'd5;
  localparam step_t ST_SIGN  = 3'd6;

  typedef enum logic {OPA_SEED, OPA_STATE} opa_t;
  typedef enum logic {OPB_MULT, OPB_RANGE} opb_t;
  typedef enum logic [1:0] {RES_ZERO, RES_SIGN, RES_RANGE, RES_DEGEN} res_t;
  typedef enum logic [1:0] {COND_NONE, COND_DEGEN, COND_SIGN} cond_t;

  // One control word of the microprogram
  typedef struct packed {
    opa_t  opa;
    opb_t  opb;
    logic  wr_state;
    logic  ld_range;
    logic  wr_prod;
    res_t  res;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  // Datapath status fed back to the sequencer for jumps
  typedef struct packed {
    logic degen;
    logic sign_op;
  } stat_t;

  // Control store
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c = '0;
    unique case (s)
      ST_SEED: begin
        c.opa = OPA_SEED;
        c.opb = OPB_MULT;
        c.wr_state = 1'b1;
        c.res = RES_ZERO;
        c.last = 1'b1;
      end
      ST_CHECK: begin
        c.ld_range = 1'b1;
        c.cond = COND_DEGEN;
        c.target = ST_DEGEN;
      end
      ST_ADV: begin
        c.opa = OPA_STATE;
        c.opb = OPB_MULT;
        c.wr_state = 1'b1;
        c.cond = COND_SIGN;
        c.target = ST_SIGN;
      end
      ST_SCALE: begin
        c.opa = OPA_STATE;
        c.opb = OPB_RANGE;
        c.wr_prod = 1'b1;
      end
      ST_SUM: begin
        c.res = RES_RANGE;
        c.last = 1'b1;
      end
      ST_DEGEN: begin
        c.res = RES_DEGEN;
        c.last = 1'b1;
      end
      ST_SIGN: begin
        c.res = RES_SIGN;
        c.last = 1'b1;
      end
      default: begin
        c.last = 1'b1;
      end
    endcase
    return c;
  endfunction

  // Multiplier used by each opcode; number draws share the length multiplier
  function automatic logic [DATA_W-1:0] pick_mult(
    logic [OP_W-1:0]   op,
    logic [DATA_W-1:0] m_sign,
    logic [DATA_W-1:0] m_weight,
    logic [DATA_W-1:0] m_number_seed,
    logic [DATA_W-1:0] m_length
  );
    logic [DATA_W-1:0] m;
    unique case (op) inside
      OP_SEED_LENGTH, OP_DRAW_LENGTH, OP_DRAW_NUMBER: m = m_length;
      OP_SEED_WEIGHT, OP_DRAW_WEIGHT:                 m = m_weight;
      OP_SEED_SIGN, OP_DRAW_SIGN:                     m = m_sign;
      OP_SEED_NUMBER:                                 m = m_number_seed;
      default:                                        m = m_length;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/multi_stream_lcg_range_draw.sv
// Channel  Ports                                      Handshake
// -------  -----------------------------------------  ---------------
// in       in_opcode, in_seed, in_low_bound, in_high_bound  valid/ready
// out      out_value                                  valid/ready
// cfg      cfg_we, cfg_index, cfg_wdata               write enable
//
// A seed takes 1 step, a sign draw 3, a weight draw on a one-point or empty
// interval 2 and a range draw 4, using one shared 32x32 multiplier; the last
// step loads the output register, and the next transaction is taken the cycle
// after, even while that result still waits.
// The final step holds while the output register is full and not being read.
// Synchronous active-low reset clears the states, sets the multipliers to 16807.
module multi_stream_lcg_range_draw (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [mslrd_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [mslrd_pkg::DATA_W-1:0]  in_seed,
  input  logic signed [mslrd_pkg::DATA_W-1:0]  in_low_bound,
  input  logic signed [mslrd_pkg::DATA_W-1:0]  in_high_bound,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mslrd_pkg::DATA_W-1:0]  out_value,
  input  logic                                 cfg_we,
  input  logic [mslrd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mslrd_pkg::DATA_W-1:0]         cfg_wdata
);

  `include "multi_stream_lcg_range_draw_macros.svh"

  localparam int unsigned W = mslrd_pkg::DATA_W;

  logic [W-1:0]                    mult_sign_r, mult_weight_r;
  logic [W-1:0]                    mult_number_seed_r, mult_length_r;
  logic [mslrd_pkg::OP_W-1:0]      op_r;
  logic [W-1:0]                    seed_r, low_r, high_r;
  logic                            out_valid_r;
  logic [W-1:0]                    out_value_r;
  logic                            in_fire, out_free;
  logic                            busy, exec, done;
  mslrd_pkg::ctrl_t                ctrl;
  mslrd_pkg::stat_t                stat;
  logic [W-1:0]                    mult;
  logic [W-1:0]                    dp_value;
  logic                            seed_done, sign_done;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_sign_r        <= mslrd_pkg::MULT_RESET;
      mult_weight_r      <= mslrd_pkg::MULT_RESET;
      mult_number_seed_r <= mslrd_pkg::MULT_RESET;
      mult_length_r      <= mslrd_pkg::MULT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mslrd_pkg::CFG_MULT_SIGN:        mult_sign_r        <= cfg_wdata;
        mslrd_pkg::CFG_MULT_WEIGHT:      mult_weight_r      <= cfg_wdata;
        mslrd_pkg::CFG_MULT_NUMBER_SEED: mult_number_seed_r <= cfg_wdata;
        mslrd_pkg::CFG_MULT_LENGTH:      mult_length_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_opcode;
      seed_r <= in_seed;
      low_r  <= in_low_bound;
      high_r <= in_high_bound;
    end
  end

  assign mult = mslrd_pkg::pick_mult(op_r, mult_sign_r, mult_weight_r,
                                     mult_number_seed_r, mult_length_r);

  mslrd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .op       (in_opcode),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (busy),
    .exec     (exec),
    .done     (done)
  );

  mslrd_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .exec  (exec),
    .op    (op_r),
    .seed  (seed_r),
    .low   (low_r),
    .high  (high_r),
    .mult  (mult),
    .stat  (stat),
    .value (dp_value)
  );

  // Output register: load on the final step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_value_r <= dp_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  assign seed_done = done && !op_r[mslrd_pkg::OP_W-1];
  assign sign_done = done && (op_r == mslrd_pkg::OP_DRAW_SIGN);

  `MSLRD_ASSERT_NXT(a_accept_starts_program, in_valid && in_ready, busy, "accept did not start")
  `MSLRD_ASSERT_IMP(a_out_from_done, out_valid_r && !$past(out_valid_r), $past(done), "stray result")
  `MSLRD_ASSERT_IMP(a_seed_gives_zero, seed_done, dp_value == '0, "seed returned nonzero")
  `MSLRD_ASSERT_IMP(a_sign_is_bit, sign_done, dp_value[W-1:1] == '0, "sign wider than one bit")

endmodule

FILE: hw/rtl/mslrd_seq.sv
module mslrd_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_fire,
  input  logic [mslrd_pkg::OP_W-1:0]     op,
  input  mslrd_pkg::stat_t               stat,
  input  logic                           out_free,
  output mslrd_pkg::ctrl_t               ctrl,
  output logic                           busy,
  output logic                           exec,
  output logic                           done
);

  logic                  busy_r, busy_nxt;
  mslrd_pkg::step_t      step_r, step_nxt;
  logic                  jump;

  // Fetch the control word of the current step
  assign ctrl = mslrd_pkg::ucode(step_r);
  assign busy = busy_r;

  // Evaluate the jump condition
  always_comb begin
    unique case (ctrl.cond)
      mslrd_pkg::COND_DEGEN: jump = stat.degen;
      mslrd_pkg::COND_SIGN:  jump = stat.sign_op;
      default:               jump = 1'b0;
    endcase
  end

  // Hold the last step while the output register is still full
  assign exec = busy_r && !(ctrl.last && !out_free);
  assign done = busy_r && ctrl.last && out_free;

  // Advance the step counter
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
      step_nxt = op[mslrd_pkg::OP_W-1] ? mslrd_pkg::ST_CHECK : mslrd_pkg::ST_SEED;
    end else if (exec) begin
      if (ctrl.last) begin
        busy_nxt = 1'b0;
      end else if (jump) begin
        step_nxt = ctrl.target;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= mslrd_pkg::ST_SEED;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

FILE: hw/rtl/mslrd_dp.sv
module mslrd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mslrd_pkg::ctrl_t                  ctrl,
  input  logic                              exec,
  input  logic [mslrd_pkg::OP_W-1:0]        op,
  input  logic [mslrd_pkg::DATA_W-1:0]      seed,
  input  logic [mslrd_pkg::DATA_W-1:0]      low,
  input  logic [mslrd_pkg::DATA_W-1:0]      high,
  input  logic [mslrd_pkg::DATA_W-1:0]      mult,
  output mslrd_pkg::stat_t                  stat,
  output logic [mslrd_pkg::DATA_W-1:0]      value
);

  localparam int unsigned W = mslrd_pkg::DATA_W;

  logic [W-1:0]                    state_r [mslrd_pkg::STREAMS];
  logic [W-1:0]                    range_r;
  logic signed [2*W-1:0]           prod_r;
  logic [mslrd_pkg::SIDX_W-1:0]    sidx;
  logic [W-1:0]                    opa, opb;
  logic signed [2*W-1:0]           prod;
  logic                            corr;
  logic [W-1:0]                    sum;
  logic                            empty;

  assign sidx = op[mslrd_pkg::SIDX_W-1:0];

  // Shared multiplier with operand select
  assign opa  = (ctrl.opa == mslrd_pkg::OPA_SEED) ? seed : state_r[sidx];
  assign opb  = (ctrl.opb == mslrd_pkg::OPB_MULT) ? mult : range_r;
  assign prod = $signed(opa) * $signed(opb);

  // Update generator state, masked to 31 bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < mslrd_pkg::STREAMS; i++) begin
        state_r[i] <= '0;
      end
    end else if (exec && ctrl.wr_state) begin
      state_r[sidx] <= {1'b0, prod[W-2:0]};
    end
  end

  // Capture the range and the scaled product
  always_ff @(posedge clk) begin
    if (exec && ctrl.ld_range) begin
      range_r <= high - low + 32'd1;
    end
    if (exec && ctrl.wr_prod) begin
      prod_r <= prod;
    end
  end

  // Shift by 31 rounding toward zero, then offset by the lower bound
  assign corr = prod_r[2*W-1] && (|prod_r[W-2:0]);
  assign sum  = low + prod_r[2*W-2:W-1] + {{(W-1){1'b0}}, corr};

  assign empty = $signed(high) < $signed(low);

  // Jump conditions
  assign stat.degen   = (op == mslrd_pkg::OP_DRAW_WEIGHT) && ($signed(high) <= $signed(low));
  assign stat.sign_op = (op == mslrd_pkg::OP_DRAW_SIGN);

  // Select the result
  always_comb begin
    unique case (ctrl.res)
      mslrd_pkg::RES_SIGN:  value = {{(W-1){1'b0}}, state_r[sidx][15]};
      mslrd_pkg::RES_RANGE: value = sum;
      mslrd_pkg::RES_DEGEN: value = empty ? '0 : low;
      default:              value = '0;
    endcase
  end

endmodule

FILE: tb/multi_stream_lcg_range_draw_tb.sv
module multi_stream_lcg_range_draw_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mslrd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_opcode = '0;
  logic signed [DATA_W-1:0] in_seed = '0;
  logic signed [DATA_W-1:0] in_low_bound = '0;
  logic signed [DATA_W-1:0] in_high_bound = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the multipliers and the four generator states
  logic [DATA_W-1:0] mult_reg [STREAMS];
  logic [DATA_W-1:0] length_x;
  logic [DATA_W-1:0] weight_x;
  logic [DATA_W-1:0] sign_x;
  logic [DATA_W-1:0] number_x;

  logic [DATA_W-1:0] expected_values [$];
  logic [DATA_W-1:0] want_value;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  multi_stream_lcg_range_draw i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_seed      (in_seed),
    .in_low_bound (in_low_bound),
    .in_high_bound(in_high_bound),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advance one generator: 32-bit wrapped product, top bit cleared
  function automatic logic [DATA_W-1:0] lcg_next(logic [DATA_W-1:0] x, logic [DATA_W-1:0] a);
    logic [DATA_W-1:0] p;
    p = x * a;
    return {1'b0, p[DATA_W-2:0]};
  endfunction

  // Map a state into [lo, hi]: lo + trunc(x * span / 2^31), span may wrap
  function automatic logic [DATA_W-1:0] scale_into(logic [DATA_W-1:0] x,
                                                   logic [DATA_W-1:0] lo,
                                                   logic [DATA_W-1:0] hi);
    logic [DATA_W-1:0] span;
    longint prod;
    longint quot;
    span = hi - lo + 32'd1;
    prod = longint'(x) * longint'($signed(span));
    if (prod < 0) quot = -((-prod) >>> 31);
    else quot = prod >>> 31;
    return lo + quot[DATA_W-1:0];
  endfunction

  // Apply one accepted transaction to the predictor and return its value
  function automatic logic [DATA_W-1:0] predict_draw(logic [OP_W-1:0] op,
                                                     logic [DATA_W-1:0] seed,
                                                     logic [DATA_W-1:0] lo,
                                                     logic [DATA_W-1:0] hi);
    logic [DATA_W-1:0] res;
    res = '0;
    case (op)
      OP_SEED_LENGTH: length_x = lcg_next(seed, mult_reg[CFG_MULT_LENGTH]);
      OP_SEED_WEIGHT: weight_x = lcg_next(seed, mult_reg[CFG_MULT_WEIGHT]);
      OP_SEED_SIGN:   sign_x = lcg_next(seed, mult_reg[CFG_MULT_SIGN]);
      OP_SEED_NUMBER: number_x = lcg_next(seed, mult_reg[CFG_MULT_NUMBER_SEED]);
      OP_DRAW_LENGTH: begin
        length_x = lcg_next(length_x, mult_reg[CFG_MULT_LENGTH]);
        res = scale_into(length_x, lo, hi);
      end
      OP_DRAW_WEIGHT: begin
        // empty and one-point intervals leave the weight stream alone
        if ($signed(hi) < $signed(lo)) begin
          res = '0;
        end else if (hi == lo) begin
          res = lo;
        end else begin
          weight_x = lcg_next(weight_x, mult_reg[CFG_MULT_WEIGHT]);
          res = scale_into(weight_x, lo, hi);
        end
      end
      OP_DRAW_SIGN: begin
        sign_x = lcg_next(sign_x, mult_reg[CFG_MULT_SIGN]);
        res = {31'b0, sign_x[15]};
      end
      default: begin
        // number draws advance with the length multiplier
        number_x = lcg_next(number_x, mult_reg[CFG_MULT_LENGTH]);
        res = scale_into(number_x, lo, hi);
      end
    endcase
    return res;
  endfunction

  // Present one transaction after a random gap and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] seed,
                           input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_seed <= seed;
    in_low_bound <= lo;
    in_high_bound <= hi;
    do @(posedge clk); while (!in_ready);
    expected_values.push_back(predict_draw(op, seed, lo, hi));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four multipliers on consecutive cycles; block must be idle
  task automatic write_multipliers(input logic [DATA_W-1:0] m_sign,
                                   input logic [DATA_W-1:0] m_weight,
                                   input logic [DATA_W-1:0] m_number_seed,
                                   input logic [DATA_W-1:0] m_length);
    logic [DATA_W-1:0] vals [STREAMS];
    logic [CFG_IDX_W-1:0] idx [STREAMS];
    vals = '{m_sign, m_weight, m_number_seed, m_length};
    idx = '{CFG_MULT_SIGN, CFG_MULT_WEIGHT, CFG_MULT_NUMBER_SEED, CFG_MULT_LENGTH};
    cfg_we <= 1'b1;
    for (int i = 0; i < STREAMS; i++) begin
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      mult_reg[idx[i]] = vals[i];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_multiplier();
    case ($urandom_range(0, 5))
      0: return 32'd16807;
      1: return 32'd48271;
      2: return 32'd69621;
      3: return 32'h41C6_4E6D;
      default: return $urandom | 32'd1;
    endcase
  endfunction

  // Interval mix: narrow, wide, one-point, reversed, extremes
  task automatic pick_bounds(output logic [DATA_W-1:0] lo, output logic [DATA_W-1:0] hi);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        lo = $urandom_range(0, 2000) - 1000;
        hi = lo + $urandom_range(0, 200);
      end
      3: begin
        lo = $urandom;
        hi = lo + $urandom_range(1, 65535);
      end
      4: begin
        lo = $urandom;
        hi = lo;
      end
      5: begin
        lo = $urandom;
        hi = lo - $urandom_range(1, 1000);
      end
      6: begin
        lo = $urandom;
        hi = $urandom;
      end
      7: begin
        lo = 32'h8000_0000;
        hi = $urandom_range(0, 1) ? 32'h7FFF_FFFF : $urandom;
      end
      8: begin
        lo = $urandom;
        hi = 32'h7FFF_FFFF;
      end
      default: begin
        lo = '0;
        hi = $urandom_range(1, 10);
      end
    endcase
  endtask

  // Extremes of every field and each corner of the draw rules, reset multipliers
  task automatic test_edge_cases();
    send_item(OP_DRAW_LENGTH, 0, 0, 99);
    send_item(OP_SEED_LENGTH, 32'h7FFF_FFFF, 0, 0);
    send_item(OP_SEED_WEIGHT, 32'h8000_0000, 0, 0);
    send_item(OP_SEED_SIGN, 12345, 0, 0);
    send_item(OP_SEED_NUMBER, 32'hFFFF_FFFF, 0, 0);
    send_item(OP_DRAW_LENGTH, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_DRAW_LENGTH, 0, 100, -100);
    send_item(OP_DRAW_LENGTH, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_DRAW_WEIGHT, 0, 10, 5);
    send_item(OP_DRAW_WEIGHT, 0, -7, -7);
    send_item(OP_DRAW_WEIGHT, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_DRAW_WEIGHT, 0, 1, 6);
    send_item(OP_DRAW_WEIGHT, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(OP_DRAW_SIGN, 0, 0, 0);
    send_item(OP_DRAW_SIGN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_DRAW_SIGN, 0, 0, 0);
    send_item(OP_DRAW_NUMBER, 0, 0, 32'h7FFF_FFFF);
    send_item(OP_DRAW_NUMBER, 0, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_DRAW_NUMBER, 0, -50, 50);
    send_item(OP_SEED_LENGTH, 0, 0, 0);
    send_item(OP_DRAW_LENGTH, 0, -1000, 1000);
    drain_results();
  endtask

  // Degenerate and distinct multipliers; number draws must follow mult_length
  task automatic test_multiplier_extremes();
    write_multipliers(32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000);
    for (int i = 0; i < 2; i++) begin
      for (int s = 0; s < STREAMS; s++) send_item(OP_W'(s), $urandom, 0, 0);
      for (int s = 0; s < STREAMS; s++) send_item(OP_W'(s + 4), 0, -300, 300);
    end
    drain_results();
    write_multipliers(32'hFFFF_FFFF, 32'h8000_0001, 32'h0000_BC8F, 32'h41C6_4E6D);
    send_item(OP_SEED_NUMBER, $urandom, 0, 0);
    send_item(OP_SEED_LENGTH, $urandom, 0, 0);
    for (int i = 0; i < 4; i++) begin
      send_item(OP_DRAW_NUMBER, 0, 0, 1_000_000);
      send_item(OP_DRAW_LENGTH, 0, 0, 1_000_000);
      send_item(OP_DRAW_WEIGHT, 0, -1_000_000, 1_000_000);
      send_item(OP_DRAW_SIGN, 0, 0, 0);
    end
    drain_results();
  endtask

  // Mostly draws with fresh seeds now and then, under the given stall rates
  task automatic test_random_traffic(input int count, input int s_pct, input int r_pct);
    logic [OP_W-1:0] op;
    logic [DATA_W-1:0] seed;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int blk = 0; blk < 2; blk++) begin
      write_multipliers(pick_multiplier(), pick_multiplier(), pick_multiplier(),
                        pick_multiplier());
      for (int n = 0; n < count / 2; n++) begin
        if ($urandom_range(0, 9) < 2) op = OP_W'($urandom_range(0, 3));
        else op = OP_W'(4 + $urandom_range(0, 3));
        case ($urandom_range(0, 15))
          0: seed = '0;
          1: seed = 32'h8000_0000;
          2: seed = 32'h7FFF_FFFF;
          default: seed = $urandom;
        endcase
        pick_bounds(lo, hi);
        send_item(op, seed, lo, hi);
      end
      drain_results();
    end
  endtask

  // Receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        $error("out_value: no result expected, actual %0d", out_value);
        mismatch_count++;
      end else begin
        want_value = expected_values.pop_front();
        if (out_value !== want_value) begin
          $error("out_value: expected %0d, actual %0d", $signed(want_value), out_value);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STREAMS; i++) mult_reg[i] = MULT_RESET;
    length_x = '0;
    weight_x = '0;
    sign_x = '0;
    number_x = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_multiplier_extremes();
    test_random_traffic(260, 36, 51);
    test_random_traffic(260, 51, 36);
    test_random_traffic(260, 0, 0);
    drain_results();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
